FILE: design/rssc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssc_pkg: shared types and constants of the row convolution
// Widths, register indexes and the job and configuration records that
// travel between the window, multiply and rounding stages.
// ----------------------------------------------------------------------------
package rssc_pkg;

    localparam int MAX_TAPS  = 7;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int TAP_W     = 3;
    localparam int SEEN_W    = 3;
    localparam int FRAC_BITS = 14;
    localparam int AGE_W     = $clog2(MAX_TAPS);
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int NPART     = (MAX_TAPS + 1) / 2;
    localparam int PART_W    = PROD_W + 1;
    localparam int ACC_W     = PROD_W + $clog2(MAX_TAPS) + 1;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 16;
    localparam int MAX_STUMP = MAX_TAPS / 2;

    localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_TAPS);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST  = CFG_IDX_W'(MAX_TAPS);

    localparam logic [TAP_W-1:0]  TAP_RESET   = TAP_W'(1);
    localparam logic [COEF_W-1:0] COEF0_RESET = COEF_W'(1 << FRAC_BITS);

    typedef struct packed {
        logic [TAP_W-1:0]                    taps;
        logic [MAX_TAPS-1:0][COEF_W-1:0]     coef;
    } t_cfg;

    // One output to compute: the sample window (age 0 is newest), the delay
    // of the output behind the newest sample and the end-of-row flag.
    typedef struct packed {
        logic [MAX_TAPS-1:0][SAMPLE_W-1:0]   win;
        logic [TAP_W-1:0]                    d;
        logic                                last;
    } t_job;

endpackage

FILE: design/rssc_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssc_window: sample history and output scheduling
// Keeps the previous samples of the row, decides which outputs each beat
// owes and walks the end-of-row flush one output per cycle while i_en is high.
// ----------------------------------------------------------------------------
module rssc_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [rssc_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_last,
    input  logic [rssc_pkg::TAP_W-1:0]    i_taps,
    output logic                          o_ready,
    output logic                          o_job_valid,
    output rssc_pkg::t_job                o_job
);

    logic [rssc_pkg::MAX_TAPS-2:0][rssc_pkg::SAMPLE_W-1:0] r_hist;
    logic [rssc_pkg::MAX_TAPS-1:0][rssc_pkg::SAMPLE_W-1:0] win_now;
    logic [rssc_pkg::SEEN_W-1:0] r_seen;
    logic [rssc_pkg::TAP_W-1:0]  r_flush_d;
    logic                        r_flush;
    logic                        r_job_valid;
    rssc_pkg::t_job              r_job;
    logic [rssc_pkg::TAP_W-1:0]  stump;
    logic [rssc_pkg::TAP_W-1:0]  cnt_m1;
    logic                        accept;

    assign stump   = i_taps >> 1;
    assign o_ready = i_en && !r_flush;
    assign accept  = i_valid && o_ready;
    // Outputs still owed at row end, minus one.
    assign cnt_m1  = (rssc_pkg::TAP_W'(r_seen) < stump) ? rssc_pkg::TAP_W'(r_seen) : stump;

    always_comb begin
        win_now[0] = i_sample;
        for (int a = 1; a < rssc_pkg::MAX_TAPS; a++) begin
            win_now[a] = r_hist[a-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_flush     <= 1'b0;
            r_flush_d   <= '0;
            r_seen      <= '0;
            r_hist      <= '0;
        end else if (i_en) begin
            if (r_flush) begin
                r_job_valid <= 1'b1;
                r_flush_d   <= r_flush_d - rssc_pkg::TAP_W'(1);
                if (r_flush_d == '0) begin
                    r_flush <= 1'b0;
                end
            end else if (accept) begin
                if (!i_last) begin
                    r_job_valid <= (rssc_pkg::TAP_W'(r_seen) >= stump);
                    r_hist      <= win_now[rssc_pkg::MAX_TAPS-2:0];
                    if (r_seen < rssc_pkg::SEEN_MAX) begin
                        r_seen <= r_seen + rssc_pkg::SEEN_W'(1);
                    end
                end else begin
                    r_job_valid <= 1'b1;
                    r_hist      <= '0;
                    r_seen      <= '0;
                    if (cnt_m1 != '0) begin
                        r_flush   <= 1'b1;
                        r_flush_d <= cnt_m1 - rssc_pkg::TAP_W'(1);
                    end
                end
            end else begin
                r_job_valid <= 1'b0;
            end
        end
    end

    // The window is held across the flush; only delay and flag move.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_flush) begin
                r_job.d    <= r_flush_d;
                r_job.last <= (r_flush_d == '0);
            end else if (accept) begin
                r_job.win <= win_now;
                if (!i_last) begin
                    r_job.d    <= stump;
                    r_job.last <= 1'b0;
                end else begin
                    r_job.d    <= cnt_m1;
                    r_job.last <= (cnt_m1 == '0);
                end
            end
        end
    end

    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

    a_flush_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> !o_ready)
        else $error("input taken during row flush");

    a_row_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last) |=> (r_seen == '0 && r_hist == '0))
        else $error("history not cleared after row end");

    a_flush_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> (r_flush_d < rssc_pkg::TAP_W'(rssc_pkg::MAX_STUMP)))
        else $error("flush count out of range");

    a_last_ends_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_job_valid && r_job.last) |-> !r_flush)
        else $error("row end output emitted while flush still running");

endmodule

FILE: design/rssc_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssc_mac: tap products and partial sums
// Selects the sample under each tap, multiplies by its coefficient in one
// stage and adds the products in pairs in the next.
// ----------------------------------------------------------------------------
module rssc_mac (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_job_valid,
    input  rssc_pkg::t_job              i_job,
    input  rssc_pkg::t_cfg              i_cfg,
    output logic                        o_valid,
    output logic                        o_last,
    output logic [rssc_pkg::NPART-1:0][rssc_pkg::PART_W-1:0] o_part
);

    localparam int AW = rssc_pkg::AGE_W + 2;

    logic [rssc_pkg::MAX_TAPS-1:0][rssc_pkg::SAMPLE_W-1:0] opnd;
    logic signed [rssc_pkg::PROD_W-1:0] r_prod [rssc_pkg::MAX_TAPS];
    logic signed [rssc_pkg::PROD_W-1:0] prod_pad [2*rssc_pkg::NPART];
    logic [rssc_pkg::NPART-1:0][rssc_pkg::PART_W-1:0] n_part;
    logic [rssc_pkg::NPART-1:0][rssc_pkg::PART_W-1:0] r_part;
    logic [rssc_pkg::TAP_W-1:0] stump;
    logic r_p_valid;
    logic r_p_last;
    logic r_q_valid;
    logic r_q_last;

    assign stump = i_cfg.taps >> 1;

    // Tap m reads the sample of age d - stump + m; outside the row it is zero.
    always_comb begin
        logic signed [AW-1:0] age;
        for (int m = 0; m < rssc_pkg::MAX_TAPS; m++) begin
            age = $signed(AW'(i_job.d)) + $signed(AW'(m)) - $signed(AW'(stump));
            if ((AW'(m) < AW'(i_cfg.taps)) && (age >= 0)
                && (age < $signed(AW'(rssc_pkg::MAX_TAPS)))) begin
                opnd[m] = i_job.win[age[rssc_pkg::AGE_W-1:0]];
            end else begin
                opnd[m] = '0;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 2*rssc_pkg::NPART; k++) begin
            prod_pad[k] = '0;
        end
        for (int k = 0; k < rssc_pkg::MAX_TAPS; k++) begin
            prod_pad[k] = r_prod[k];
        end
        for (int k = 0; k < rssc_pkg::NPART; k++) begin
            n_part[k] = rssc_pkg::PART_W'(prod_pad[2*k]) + rssc_pkg::PART_W'(prod_pad[2*k+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_q_valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid <= i_job_valid;
            r_q_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int m = 0; m < rssc_pkg::MAX_TAPS; m++) begin
                r_prod[m] <= $signed(opnd[m]) * $signed(i_cfg.coef[m]);
            end
            r_p_last <= i_job.last;
            r_part   <= n_part;
            r_q_last <= r_p_last;
        end
    end

    assign o_valid = r_q_valid;
    assign o_last  = r_q_last;
    assign o_part  = r_part;

endmodule

FILE: design/rssc_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssc_round: final sum, rounding and saturation
// Adds the partial sums, rounds half up at the Q2.14 point, clamps to
// 16 bits and holds the result beat in the output register.
// ----------------------------------------------------------------------------
module rssc_round (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic                          i_last,
    input  logic [rssc_pkg::NPART-1:0][rssc_pkg::PART_W-1:0] i_part,
    output logic                          o_valid,
    output logic                          o_last,
    output logic [rssc_pkg::SAMPLE_W-1:0] o_value
);

    localparam logic signed [rssc_pkg::ACC_W-1:0] HALF =
        rssc_pkg::ACC_W'(1 << (rssc_pkg::FRAC_BITS - 1));
    localparam logic signed [rssc_pkg::ACC_W-1:0] SAT_HI =
        rssc_pkg::ACC_W'((1 << (rssc_pkg::SAMPLE_W - 1)) - 1);
    localparam logic signed [rssc_pkg::ACC_W-1:0] SAT_LO = -SAT_HI - 1;

    logic signed [rssc_pkg::ACC_W-1:0] acc;
    logic signed [rssc_pkg::ACC_W-1:0] q;
    logic [rssc_pkg::SAMPLE_W-1:0]     value_n;
    logic                              r_valid;
    logic                              r_last;
    logic [rssc_pkg::SAMPLE_W-1:0]     r_value;

    always_comb begin
        acc = HALF;
        for (int k = 0; k < rssc_pkg::NPART; k++) begin
            acc = acc + rssc_pkg::ACC_W'($signed(i_part[k]));
        end
        // Arithmetic shift floors, which with the half added rounds half up.
        q = acc >>> rssc_pkg::FRAC_BITS;
        if (q > SAT_HI) begin
            value_n = SAT_HI[rssc_pkg::SAMPLE_W-1:0];
        end else if (q < SAT_LO) begin
            value_n = SAT_LO[rssc_pkg::SAMPLE_W-1:0];
        end else begin
            value_n = q[rssc_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= value_n;
            r_last  <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;
    assign o_value = r_value;

endmodule

FILE: design/row_same_size_convolution.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_same_size_convolution: centered same-length FIR over rows
// Filters each row with a kernel of up to seven Q2.14 taps, samples outside
// the row taken as zero, results rounded and saturated to 16 bits.
// ----------------------------------------------------------------------------
// Usage:
//   Samples arrive on the s_axis channel, one per beat, with tlast on the
//   final sample of each row. Filtered samples leave on m_axis, tlast marking
//   the final result of the row. Each row gives exactly as many results as
//   it had samples.
//   The configuration port writes tap_count (index 0) and coef_0..coef_6
//   (indexes 1..7); write it only while no row is in flight.
//   Throughput is one beat per cycle while m_axis is not stalled and no row
//   flush runs. A result reaches m_axis through the window, product,
//   partial-sum and output registers. The first tap_count/2 beats of a row
//   produce no result; the row-end beat then produces tap_count/2 + 1
//   results (fewer on short rows), and s_axis_tready stays low for the extra
//   cycles this flush takes.
//   When a result waits with m_axis_tready low, the whole pipeline holds and
//   s_axis_tready drops in the same cycle. Reset clears the history, pipeline
//   valids and the registers to tap_count 1, coef_0 1.0 and all other taps
//   zero.
// ----------------------------------------------------------------------------
module row_same_size_convolution (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rssc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rssc_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,  // [15:0] sample
    input  logic                           s_axis_tlast,  // row_end
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [15:0]                    m_axis_tdata,  // [15:0] value
    output logic                           m_axis_tlast   // last_of_row
);

    rssc_pkg::t_cfg r_cfg;
    rssc_pkg::t_job job;
    logic           job_valid;
    logic           en;
    logic           mac_valid;
    logic           mac_last;
    logic [rssc_pkg::NPART-1:0][rssc_pkg::PART_W-1:0] mac_part;

    // The pipeline moves whenever the output register is free or drained.
    assign en = !m_axis_tvalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.taps <= rssc_pkg::TAP_RESET;
            r_cfg.coef <= {{((rssc_pkg::MAX_TAPS - 1) * rssc_pkg::COEF_W){1'b0}},
                           rssc_pkg::COEF0_RESET};
        end else if (i_cfg_we) begin
            if (i_cfg_index == rssc_pkg::REG_TAP_COUNT) begin
                r_cfg.taps <= i_cfg_wdata[rssc_pkg::TAP_W-1:0];
            end else if (i_cfg_index inside
                         {[rssc_pkg::REG_COEF_FIRST:rssc_pkg::REG_COEF_LAST]}) begin
                r_cfg.coef[rssc_pkg::AGE_W'(i_cfg_index - rssc_pkg::REG_COEF_FIRST)]
                    <= i_cfg_wdata[rssc_pkg::COEF_W-1:0];
            end
        end
    end

    rssc_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (s_axis_tvalid),
        .i_sample    (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_taps      (r_cfg.taps),
        .o_ready     (s_axis_tready),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    rssc_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_job_valid (job_valid),
        .i_job       (job),
        .i_cfg       (r_cfg),
        .o_valid     (mac_valid),
        .o_last      (mac_last),
        .o_part      (mac_part)
    );

    rssc_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (mac_valid),
        .i_last  (mac_last),
        .i_part  (mac_part),
        .o_valid (m_axis_tvalid),
        .o_last  (m_axis_tlast),
        .o_value (m_axis_tdata)
    );

endmodule

FILE: bench/tb_row_same_size_convolution.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_row_same_size_convolution: self-checking bench for the row convolution
// A table of directed rows and register writes is walked first, then random
// rows under several kernels and four flow-control phases. Every accepted
// sample is run through a local model of the centered FIR, and each result
// beat is checked field by field against the oldest predicted output.
// ----------------------------------------------------------------------------
module tb_row_same_size_convolution;

    localparam int          CLK_HALF   = 5;
    localparam int          RST_CYCLES = 7;
    localparam int          FLUSH_WAIT = 16;
    localparam int          CYCLE_CAP  = 300000;
    localparam int          SEG_BEATS  = 22;
    localparam int          NUM_SEGS   = 8;
    localparam int          NTAPS      = rssc_pkg::MAX_TAPS;
    // Index past the last coefficient; the block must ignore writes to it.
    localparam logic [rssc_pkg::CFG_IDX_W-1:0] REG_UNUSED = '1;

    typedef enum logic { STEP_CFG, STEP_BEAT } t_step_kind;

    typedef struct {
        t_step_kind                     kind;
        logic [rssc_pkg::CFG_IDX_W-1:0] idx;
        logic [15:0]                    data;
        logic                           row_end;
        logic                           fixed;
        logic [15:0]                    ev;
    } t_step;

    typedef struct {
        logic [15:0] value;
        logic        last;
    } t_out_beat;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [rssc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rssc_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [15:0]                    s_tdata = '0;
    logic                           s_tlast = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b1;
    logic [15:0]                    m_tdata;
    logic                           m_tlast;

    // Local copy of the registers and the row history (newest sample first).
    logic [2:0]                     taps_reg;
    logic [NTAPS-1:0][15:0]         coef_reg;
    logic [NTAPS-2:0][15:0]         row_hist;
    int                             seen_in_row;

    t_out_beat                      pending_out [$];
    t_out_beat                      rx_want;
    t_step                          dir_tab [$];
    int                             err_count = 0;
    int                             cycle_count = 0;
    int                             src_idle_pct = 0;
    int                             snk_stall_pct = 0;

    row_same_size_convolution i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .s_axis_tdata (s_tdata),   // [15:0] sample
        .s_axis_tlast (s_tlast),   // row_end
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_tdata),   // [15:0] value
        .m_axis_tlast (m_tlast)    // last_of_row
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (err_count < 100)
            $display("MISMATCH @%0t: %s got %h want %h", $time, what, got, want);
        err_count++;
    endtask

    // One output point: taps beyond the window edges see zero samples.
    function automatic logic [15:0] filter_point(input logic [NTAPS-1:0][15:0] win,
                                                 input int tp, input int stump,
                                                 input int d);
        longint acc;
        int     age;
        acc = 0;
        for (int m = 0; m < tp; m++) begin
            age = d - stump + m;
            if (age >= 0 && age < NTAPS)
                acc += longint'($signed(coef_reg[m])) * longint'($signed(win[age]));
        end
        acc = (acc + 8192) >>> rssc_pkg::FRAC_BITS;
        if (acc > 32767)
            return 16'h7FFF;
        else if (acc < -32768)
            return 16'h8000;
        return acc[15:0];
    endfunction

    task automatic track_sample(input logic [15:0] smp, input logic row_end);
        logic [NTAPS-1:0][15:0] win;
        int                     tp;
        int                     stump;
        int                     cnt;
        tp = int'(taps_reg);
        if (tp > NTAPS)
            tp = NTAPS;
        stump = tp / 2;
        win[0] = smp;
        for (int a = 1; a < NTAPS; a++)
            win[a] = row_hist[a-1];
        if (!row_end) begin
            if (seen_in_row >= stump)
                pending_out.push_back('{filter_point(win, tp, stump, stump), 1'b0});
            for (int a = 0; a < NTAPS - 1; a++)
                row_hist[a] = win[a];
            if (seen_in_row < 7)
                seen_in_row++;
        end else begin
            // The row end flushes every output still owed, oldest first.
            cnt = seen_in_row + 1;
            if (cnt > stump + 1)
                cnt = stump + 1;
            for (int d = cnt; d > 0; d--)
                pending_out.push_back('{filter_point(win, tp, stump, d - 1), d == 1});
            row_hist = '0;
            seen_in_row = 0;
        end
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input logic [rssc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == rssc_pkg::REG_TAP_COUNT)
            taps_reg = val[2:0];
        else if (idx >= rssc_pkg::REG_COEF_FIRST && idx <= rssc_pkg::REG_COEF_LAST)
            coef_reg[idx - rssc_pkg::REG_COEF_FIRST] = val;
        @(posedge clk);
    endtask

    // Returns at the edge that accepted the beat, with tvalid still high.
    task automatic send_beat(input logic [15:0] smp, input logic row_end);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= row_end;
        do @(posedge clk); while (!s_tready);
        track_sample(smp, row_end);
    endtask

    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (FLUSH_WAIT) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_sample();
        logic [15:0] r;
        r = 16'($urandom);
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return r;
        endcase
    endfunction

    function automatic logic [15:0] pick_coef();
        logic [15:0] r;
        r = 16'($urandom);
        case ($urandom_range(3))
            0: return r;
            1: return r[0] ? 16'h7FFF : 16'h8000;
            default: return {{3{r[12]}}, r[12:0]};
        endcase
    endfunction

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_out.size() == 0) begin
                report_mismatch("result beat with nothing expected", m_tdata, 16'h0);
            end else begin
                rx_want = pending_out.pop_front();
                if (m_tdata !== rx_want.value)
                    report_mismatch("value", m_tdata, rx_want.value);
                if (m_tlast !== rx_want.last)
                    report_mismatch("last_of_row", {15'h0, m_tlast}, {15'h0, rx_want.last});
            end
        end
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_step_kind  prev_kind;
        int          seg_count;
        int          row_len;
        int          taps_list [NUM_SEGS];
        logic [15:0] cval;

        taps_list = '{7, 0, 3, 1, 5, 2, 6, 4};
        taps_reg    = rssc_pkg::TAP_RESET;
        coef_reg    = '0;
        coef_reg[0] = rssc_pkg::COEF0_RESET;
        row_hist    = '0;
        seen_in_row = 0;

        dir_tab = '{
            // Reset kernel is a single tap of 1.0: output equals input.
            '{STEP_BEAT, '0, 16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
            '{STEP_BEAT, '0, 16'h8000, 1'b0, 1'b1, 16'h8000},
            '{STEP_BEAT, '0, 16'h0000, 1'b0, 1'b1, 16'h0000},
            '{STEP_BEAT, '0, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF},
            '{STEP_BEAT, '0, 16'h1234, 1'b1, 1'b1, 16'h1234},
            '{STEP_CFG, REG_UNUSED, 16'h0003, 1'b0, 1'b0, 16'h0},
            '{STEP_BEAT, '0, 16'h5555, 1'b1, 1'b1, 16'h5555},
            // No taps at all: zeros, one per sample.
            '{STEP_CFG, rssc_pkg::REG_TAP_COUNT, 16'h0000, 1'b0, 1'b0, 16'h0},
            '{STEP_BEAT, '0, 16'h7FFF, 1'b0, 1'b1, 16'h0000},
            '{STEP_BEAT, '0, 16'h8000, 1'b1, 1'b1, 16'h0000},
            // Largest gains drive the result into saturation.
            '{STEP_CFG, rssc_pkg::REG_TAP_COUNT, 16'h0001, 1'b0, 1'b0, 16'h0},
            '{STEP_CFG, rssc_pkg::REG_COEF_FIRST, 16'h7FFF, 1'b0, 1'b0, 16'h0},
            '{STEP_BEAT, '0, 16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
            '{STEP_BEAT, '0, 16'h8000, 1'b1, 1'b1, 16'h8000},
            '{STEP_CFG, rssc_pkg::REG_COEF_FIRST, 16'h8000, 1'b0, 1'b0, 16'h0},
            '{STEP_BEAT, '0, 16'h8000, 1'b0, 1'b1, 16'h7FFF},
            '{STEP_BEAT, '0, 16'h7FFF, 1'b1, 1'b1, 16'h8000},
            // Full seven-tap kernel over a five-sample row, then rows shorter than the center offset.
            '{STEP_CFG, rssc_pkg::REG_TAP_COUNT, 16'h0007, 1'b0, 1'b0, 16'h0},
            '{STEP_CFG, 4'(rssc_pkg::REG_COEF_FIRST + 0), 16'h1000, 1'b0, 1'b0, 16'h0},
            '{STEP_CFG, 4'(rssc_pkg::REG_COEF_FIRST + 1), 16'h2000, 1'b0, 1'b0, 16'h0},
            '{STEP_CFG, 4'(rssc_pkg::REG_COEF_FIRST + 2), 16'hC000, 1'b0, 1'b0, 16'h0},
            '{STEP_CFG, 4'(rssc_pkg::REG_COEF_FIRST + 3), 16'h4000, 1'b0, 1'b0, 16'h0},
            '{STEP_CFG, 4'(rssc_pkg::REG_COEF_FIRST + 4), 16'hE000, 1'b0, 1'b0, 16'h0},
            '{STEP_CFG, 4'(rssc_pkg::REG_COEF_FIRST + 5), 16'h0800, 1'b0, 1'b0, 16'h0},
            '{STEP_CFG, 4'(rssc_pkg::REG_COEF_FIRST + 6), 16'h7FFF, 1'b0, 1'b0, 16'h0},
            '{STEP_BEAT, '0, 16'h1000, 1'b0, 1'b0, 16'h0},
            '{STEP_BEAT, '0, 16'h8000, 1'b0, 1'b0, 16'h0},
            '{STEP_BEAT, '0, 16'h7FFF, 1'b0, 1'b0, 16'h0},
            '{STEP_BEAT, '0, 16'h0123, 1'b0, 1'b0, 16'h0},
            '{STEP_BEAT, '0, 16'hFFF0, 1'b1, 1'b0, 16'h0},
            '{STEP_BEAT, '0, 16'h4000, 1'b0, 1'b0, 16'h0},
            '{STEP_BEAT, '0, 16'h8001, 1'b1, 1'b0, 16'h0},
            '{STEP_BEAT, '0, 16'h7FFF, 1'b1, 1'b0, 16'h0},
            // Even tap counts.
            '{STEP_CFG, rssc_pkg::REG_TAP_COUNT, 16'h0004, 1'b0, 1'b0, 16'h0},
            '{STEP_BEAT, '0, 16'h2222, 1'b0, 1'b0, 16'h0},
            '{STEP_BEAT, '0, 16'hDDDD, 1'b0, 1'b0, 16'h0},
            '{STEP_BEAT, '0, 16'h0001, 1'b1, 1'b0, 16'h0},
            '{STEP_CFG, rssc_pkg::REG_TAP_COUNT, 16'hFFFA, 1'b0, 1'b0, 16'h0},
            '{STEP_BEAT, '0, 16'h6000, 1'b1, 1'b0, 16'h0},
            '{STEP_BEAT, '0, 16'h3000, 1'b0, 1'b0, 16'h0},
            '{STEP_BEAT, '0, 16'h9000, 1'b1, 1'b0, 16'h0}
        };

        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        prev_kind = STEP_CFG;
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == STEP_CFG) begin
                if (prev_kind == STEP_BEAT)
                    drain_outputs();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                if (prev_kind == STEP_CFG)
                    cfg_we <= 1'b0;
                send_beat(dir_tab[i].data, dir_tab[i].row_end);
                // Beats under a kernel of at most one tap give one result each, read straight off.
                if (dir_tab[i].fixed)
                    pending_out[$] = '{dir_tab[i].ev, dir_tab[i].row_end};
            end
            prev_kind = dir_tab[i].kind;
        end

        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            drain_outputs();
            case (seg % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 71; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 71; end
                default: begin src_idle_pct = 21; snk_stall_pct = 21; end
            endcase
            write_reg(rssc_pkg::REG_TAP_COUNT,
                      {13'($urandom), 3'(taps_list[seg])});
            for (int k = 0; k < NTAPS; k++) begin
                if (seg == 0)
                    cval = 16'h7FFF;
                else if (seg == 4)
                    cval = 16'h8000;
                else
                    cval = pick_coef();
                write_reg(4'(rssc_pkg::REG_COEF_FIRST + k), cval);
            end
            cfg_we <= 1'b0;
            seg_count = 0;
            while (seg_count < SEG_BEATS) begin
                row_len = $urandom_range(1, 10);
                for (int k = 0; k < row_len; k++)
                    send_beat(pick_sample(), k == row_len - 1);
                seg_count += row_len;
            end
        end

        drain_outputs();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
design/rssc_pkg.sv
design/rssc_window.sv
design/rssc_mac.sv
design/rssc_round.sv
design/row_same_size_convolution.sv
bench/tb_row_same_size_convolution.sv
